@@ hw/rtl/lmpg_pkg.sv @@
// Shared types and constants of the LED mode pattern generator
`timescale 1ns / 1ps

package lmpg_pkg;

  // LED mode codes, as carried on the result word
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_LISTEN = 2'd1;
  localparam logic [1:0] MODE_PROC   = 2'd2;
  localparam logic [1:0] MODE_ERROR  = 2'd3;

  // Input word command codes
  localparam logic CMD_SET_MODE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Register bank layout: one 32-bit register every 4 bytes
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_FULL_ON_DUTY = 3'd0;
  localparam logic [2:0] REG_BREATHE_MAX  = 3'd1;
  localparam logic [2:0] REG_BREATHE_MIN  = 3'd2;
  localparam logic [2:0] REG_BREATHE_STEP = 3'd3;
  localparam logic [2:0] REG_FLASH_TICKS  = 3'd4;
  localparam logic [2:0] REG_FLASH_CYCLES = 3'd5;

  // Register reset values
  localparam logic [9:0]  RST_FULL_ON_DUTY = 10'd999;
  localparam logic [9:0]  RST_BREATHE_MAX  = 10'd998;
  localparam logic [9:0]  RST_BREATHE_MIN  = 10'd1;
  localparam logic [3:0]  RST_BREATHE_STEP = 4'd2;
  localparam logic [15:0] RST_FLASH_TICKS  = 16'd200;
  localparam logic [3:0]  RST_FLASH_CYCLES = 4'd3;

  typedef struct packed {
    logic [9:0]  full_on_duty;
    logic [9:0]  breathe_max;
    logic [9:0]  breathe_min;
    logic [3:0]  breathe_step;
    logic [15:0] flash_ticks;
    logic [3:0]  flash_cycles;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  duty;
    logic [9:0]  level;
    logic        down;
    logic        blink_on;
    logic [3:0]  cycles_done;
    logic [15:0] tick_count;
  } state_t;

endpackage

@@ hw/rtl/lmpg_if.sv @@
// Valid/ready channel interfaces for command words and duty result words
`timescale 1ns / 1ps

interface lmpg_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] new_mode;

  modport source (output valid, output cmd, output new_mode, input ready);
  modport sink   (input valid, input cmd, input new_mode, output ready);
endinterface

interface lmpg_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] duty;
  logic [1:0] mode;

  modport source (output valid, output duty, output mode, input ready);
  modport sink   (input valid, input duty, input mode, output ready);
endinterface

@@ hw/rtl/led_mode_pattern_generator.sv @@
// Top level of the LED mode pattern generator: input stage, mode state, result stage
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------
//  in_if    | in        | cmd (mode request / timer tick), new_mode
//  out_if   | out       | duty (PWM compare value), mode (after the word)
//  apb      | in/out    | settings registers at byte address 4*index
//
// One word per cycle sustained while the result side is ready. A word is held in the
// input register and its result is registered in the output register as it leaves;
// the mode state updates as the word leaves the input register.
// Reset (synchronous, active low) returns the mode state and the settings to
// their defaults. A stalled result holds the output register; the input
// register keeps accepting while the result register can empty in the same cycle.
`timescale 1ns / 1ps

module led_mode_pattern_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  lmpg_in_if.sink                     in_if,
  lmpg_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lmpg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lmpg_pkg::*;

  cfg_t       cfg;
  state_t     state_r;
  state_t     state_nxt;
  logic       s1_vld_r;
  logic       s1_cmd_r;
  logic [1:0] s1_mode_r;
  logic       out_vld_r;
  logic [9:0] out_duty_r;
  logic [1:0] out_mode_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  lmpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lmpg_step u_step (
    .cfg      (cfg),
    .cur      (state_r),
    .cmd      (s1_cmd_r),
    .new_mode (s1_mode_r),
    .nxt      (state_nxt)
  );

  // Handshake: the output register frees up when empty or taken this cycle
  assign out_free    = !out_vld_r || out_if.ready;
  assign s1_adv      = s1_vld_r && out_free;
  assign in_if.ready = !s1_vld_r || out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_if.cmd;
      s1_mode_r <= in_if.new_mode;
    end
  end

  // Mode state: advance once per word leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= MODE_IDLE;
      state_r.duty        <= 10'd0;
      state_r.level       <= 10'd0;
      state_r.down        <= 1'b0;
      state_r.blink_on    <= 1'b0;
      state_r.cycles_done <= 4'd0;
      state_r.tick_count  <= 16'd0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_duty_r <= state_nxt.duty;
      out_mode_r <= state_nxt.mode;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.duty  = out_duty_r;
  assign out_if.mode  = out_mode_r;

  // Idle always drives the LED dark
  a_idle_dark : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_IDLE |-> state_r.duty == 10'd0)
    else $error("idle mode with nonzero duty");

  // A word leaving the input register lands in the result register
  a_adv_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("word lost between input and result register");

  // Mode state moves only when a word is processed
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(state_r))
    else $error("mode state changed without a word");

endmodule

@@ hw/rtl/lmpg_cfg.sv @@
// APB register bank holding the LED pattern settings
`timescale 1ns / 1ps

module lmpg_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lmpg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lmpg_pkg::cfg_t             cfg
);
  import lmpg_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write the addressed register; drop writes to unmapped slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_on_duty <= RST_FULL_ON_DUTY;
      cfg_r.breathe_max  <= RST_BREATHE_MAX;
      cfg_r.breathe_min  <= RST_BREATHE_MIN;
      cfg_r.breathe_step <= RST_BREATHE_STEP;
      cfg_r.flash_ticks  <= RST_FLASH_TICKS;
      cfg_r.flash_cycles <= RST_FLASH_CYCLES;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FULL_ON_DUTY: cfg_r.full_on_duty <= pwdata[9:0];
        REG_BREATHE_MAX:  cfg_r.breathe_max  <= pwdata[9:0];
        REG_BREATHE_MIN:  cfg_r.breathe_min  <= pwdata[9:0];
        REG_BREATHE_STEP: cfg_r.breathe_step <= pwdata[3:0];
        REG_FLASH_TICKS:  cfg_r.flash_ticks  <= pwdata[15:0];
        REG_FLASH_CYCLES: cfg_r.flash_cycles <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_FULL_ON_DUTY: prdata = {22'd0, cfg_r.full_on_duty};
      REG_BREATHE_MAX:  prdata = {22'd0, cfg_r.breathe_max};
      REG_BREATHE_MIN:  prdata = {22'd0, cfg_r.breathe_min};
      REG_BREATHE_STEP: prdata = {28'd0, cfg_r.breathe_step};
      REG_FLASH_TICKS:  prdata = {16'd0, cfg_r.flash_ticks};
      REG_FLASH_CYCLES: prdata = {28'd0, cfg_r.flash_cycles};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/lmpg_step.sv @@
// Next-state logic for one command word: mode change, breathe step or blink tick
`timescale 1ns / 1ps

module lmpg_step (
  input  lmpg_pkg::cfg_t   cfg,
  input  lmpg_pkg::state_t cur,
  input  logic             cmd,
  input  logic [1:0]       new_mode,
  output lmpg_pkg::state_t nxt
);
  import lmpg_pkg::*;

  logic [11:0] lvl_sum;
  logic        hit_max;
  logic        hit_min;
  logic [15:0] tick_inc;
  logic        half_done;
  logic [3:0]  cyc_inc;
  logic        cyc_done;

  // Breathing level moved by one step, kept signed and unwrapped
  assign lvl_sum = cur.down ? ({2'b00, cur.level} - {8'd0, cfg.breathe_step})
                            : ({2'b00, cur.level} + {8'd0, cfg.breathe_step});
  assign hit_max = $signed(lvl_sum) >= $signed({2'b00, cfg.breathe_max});
  assign hit_min = $signed(lvl_sum) <= $signed({2'b00, cfg.breathe_min});

  // Blink timing
  assign tick_inc  = cur.tick_count + 16'd1;
  assign half_done = tick_inc >= cfg.flash_ticks;
  assign cyc_inc   = cur.cycles_done + 4'd1;
  assign cyc_done  = cyc_inc >= cfg.flash_cycles;

  always_comb begin
    nxt = cur;
    if (cmd == CMD_SET_MODE) begin
      // Mode request: act only on an actual change
      if (new_mode != cur.mode) begin
        nxt.mode = new_mode;
        case (new_mode)
          MODE_IDLE:   nxt.duty = 10'd0;
          MODE_LISTEN: nxt.duty = cfg.full_on_duty;
          MODE_ERROR: begin
            nxt.cycles_done = 4'd0;
            nxt.blink_on    = 1'b1;
            nxt.tick_count  = 16'd0;
            nxt.duty        = cfg.full_on_duty;
          end
          default: ;
        endcase
      end
    end else if (cur.mode == MODE_PROC) begin
      // Breathe: upper limit checked first, then lower
      if (hit_max) begin
        nxt.level = cfg.breathe_max;
        nxt.down  = 1'b1;
      end else if (hit_min) begin
        nxt.level = cfg.breathe_min;
        nxt.down  = 1'b0;
      end else begin
        nxt.level = lvl_sum[9:0];
      end
      nxt.duty = nxt.level;
    end else if (cur.mode == MODE_ERROR) begin
      // Blink: toggle at each half period, count full cycles on turn-on
      nxt.tick_count = tick_inc;
      nxt.duty       = cur.blink_on ? cfg.full_on_duty : 10'd0;
      if (half_done) begin
        nxt.tick_count = 16'd0;
        nxt.blink_on   = ~cur.blink_on;
        if (!cur.blink_on) begin
          nxt.cycles_done = cyc_inc;
          if (cyc_done) begin
            nxt.mode = MODE_IDLE;
            nxt.duty = 10'd0;
          end else begin
            nxt.duty = cfg.full_on_duty;
          end
        end else begin
          nxt.duty = 10'd0;
        end
      end
    end
  end

endmodule

@@ test/lmpg_duty_checker.sv @@
// Duty checker: tracks register writes, predicts each duty/mode word and compares results
`timescale 1ns / 1ps

module lmpg_duty_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  lmpg_in_if                          in_ch,
  lmpg_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lmpg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);
  import lmpg_pkg::*;

  typedef struct packed {
    logic [9:0] duty;
    logic [1:0] mode;
  } duty_word_t;

  cfg_t       led_cfg;
  state_t     led;
  duty_word_t expected_words[$];
  int         results_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
  endtask

  // Leave the current mode and load what the new one drives
  function automatic void switch_mode(input logic [1:0] m);
    if (m == led.mode) return;
    led.mode = m;
    case (m)
      MODE_IDLE:   led.duty = '0;
      MODE_LISTEN: led.duty = led_cfg.full_on_duty;
      MODE_ERROR: begin
        led.cycles_done = '0;
        led.blink_on    = 1'b1;
        led.tick_count  = '0;
        led.duty        = led_cfg.full_on_duty;
      end
      default: ;
    endcase
  endfunction

  // Move the breathing level one step; the upper limit wins when limits cross
  function automatic void breathe_once();
    int nv;
    nv = int'(led.level);
    if (led.down) nv -= int'(led_cfg.breathe_step);
    else          nv += int'(led_cfg.breathe_step);
    if (nv >= int'(led_cfg.breathe_max)) begin
      led.level = led_cfg.breathe_max;
      led.down  = 1'b1;
    end else if (nv <= int'(led_cfg.breathe_min)) begin
      led.level = led_cfg.breathe_min;
      led.down  = 1'b0;
    end else begin
      led.level = nv[9:0];
    end
    led.duty = led.level;
  endfunction

  // Count one error tick; toggle at the half period, drop to idle after enough cycles
  function automatic void blink_once();
    led.tick_count = led.tick_count + 16'd1;
    if (led.tick_count >= led_cfg.flash_ticks) begin
      led.tick_count = '0;
      led.blink_on   = ~led.blink_on;
      if (led.blink_on) begin
        led.cycles_done = led.cycles_done + 4'd1;
        if (led.cycles_done >= led_cfg.flash_cycles) begin
          switch_mode(MODE_IDLE);
          return;
        end
      end
    end
    led.duty = led.blink_on ? led_cfg.full_on_duty : '0;
  endfunction

  function automatic duty_word_t apply_word(input logic cmd, input logic [1:0] new_mode);
    duty_word_t w;
    if (cmd == CMD_SET_MODE)     switch_mode(new_mode);
    else if (led.mode == MODE_PROC)  breathe_once();
    else if (led.mode == MODE_ERROR) blink_once();
    w.duty = led.duty;
    w.mode = led.mode;
    return w;
  endfunction

  always @(posedge clk) begin
    duty_word_t want;
    if (!rst_n) begin
      led_cfg.full_on_duty = RST_FULL_ON_DUTY;
      led_cfg.breathe_max  = RST_BREATHE_MAX;
      led_cfg.breathe_min  = RST_BREATHE_MIN;
      led_cfg.breathe_step = RST_BREATHE_STEP;
      led_cfg.flash_ticks  = RST_FLASH_TICKS;
      led_cfg.flash_cycles = RST_FLASH_CYCLES;
      led          = '0;
      led.mode     = MODE_IDLE;
      results_seen = 0;
      fail_count   = 0;
      expected_words.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_FULL_ON_DUTY: led_cfg.full_on_duty = pwdata[9:0];
          REG_BREATHE_MAX:  led_cfg.breathe_max  = pwdata[9:0];
          REG_BREATHE_MIN:  led_cfg.breathe_min  = pwdata[9:0];
          REG_BREATHE_STEP: led_cfg.breathe_step = pwdata[3:0];
          REG_FLASH_TICKS:  led_cfg.flash_ticks  = pwdata[15:0];
          REG_FLASH_CYCLES: led_cfg.flash_cycles = pwdata[3:0];
          default: ;
        endcase
      end
      // Compare a delivered word against the oldest prediction first
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected, duty", int'(out_ch.duty), -1);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.duty !== want.duty)
            report_mismatch("duty", int'(out_ch.duty), int'(want.duty));
          if (out_ch.mode !== want.mode)
            report_mismatch("mode", int'(out_ch.mode), int'(want.mode));
        end
        results_seen++;
      end
      // Predict the word each accepted command causes
      if (in_ch.valid && in_ch.ready)
        expected_words.push_back(apply_word(in_ch.cmd, in_ch.new_mode));
    end
    pending = expected_words.size();
  end

endmodule

@@ test/led_mode_pattern_generator_test.sv @@
// Top of the LED mode generator test: clock, reset, stimulus, register setup and verdict
`timescale 1ns / 1ps

module led_mode_pattern_generator_test;
  import lmpg_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                hold_requests;
  int                quiet_cycles;

  lmpg_in_if  in_ch ();
  lmpg_out_if out_ch ();

  led_mode_pattern_generator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lmpg_duty_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold when requested
  initial begin : receiver
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one word, idling first at random; return at the edge that takes it
  task automatic send_word(input logic cmd, input logic [1:0] new_mode);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.new_mode <= new_mode;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Setup then access; psel stays up so back-to-back writes need no drop
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [9:0] full_on, input logic [9:0] b_max,
                            input logic [9:0] b_min, input logic [3:0] b_step,
                            input logic [15:0] f_ticks, input logic [3:0] f_cycles);
    write_reg(REG_FULL_ON_DUTY, 32'(full_on));
    write_reg(REG_BREATHE_MAX,  32'(b_max));
    write_reg(REG_BREATHE_MIN,  32'(b_min));
    write_reg(REG_BREATHE_STEP, 32'(b_step));
    write_reg(REG_FLASH_TICKS,  32'(f_ticks));
    write_reg(REG_FLASH_CYCLES, 32'(f_cycles));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid, wait for every predicted word to arrive, then let the pipe drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a mode request followed by a run of ticks, with some stray words mixed in
  task automatic run_random(input int n_words);
    int sent;
    int ticks;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 15) begin
        send_word(1'($urandom), 2'($urandom));
        sent++;
      end else begin
        send_word(CMD_SET_MODE, 2'($urandom));
        sent++;
        ticks = $urandom_range(40);
        if (ticks > n_words - sent) ticks = n_words - sent;
        repeat (ticks) begin
          send_word(CMD_TICK, 2'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int lo;
    int hi;
    int tmp;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_SET_MODE;
    in_ch.new_mode = MODE_IDLE;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    src_idle_pct   = 15;
    snk_idle_pct   = 70;
    hold_requests  = 0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrow breathing range with a big step, blink with zero half period and zero cycles
    set_config(10'd1023, 10'd20, 10'd5, 4'd15, 16'd0, 4'd0);
    send_word(CMD_TICK, MODE_ERROR);       // tick while idle
    send_word(CMD_SET_MODE, MODE_IDLE);    // same mode again
    send_word(CMD_SET_MODE, MODE_LISTEN);
    send_word(CMD_TICK, MODE_PROC);        // tick while listening
    send_word(CMD_SET_MODE, MODE_PROC);    // duty held until first tick
    repeat (4) send_word(CMD_TICK, 2'($urandom));  // clamp at both limits
    send_word(CMD_SET_MODE, MODE_IDLE);
    send_word(CMD_SET_MODE, MODE_PROC);    // level and direction kept
    send_word(CMD_TICK, MODE_LISTEN);
    send_word(CMD_SET_MODE, MODE_ERROR);
    send_word(CMD_TICK, MODE_IDLE);        // half period ends on every tick
    send_word(CMD_TICK, MODE_IDLE);        // first full cycle returns to idle
    send_word(CMD_SET_MODE, MODE_ERROR);
    send_word(CMD_SET_MODE, MODE_ERROR);
    send_word(CMD_SET_MODE, MODE_IDLE);
    settle();

    // Crossed limits: upper test wins; full-on duty of zero
    set_config(10'd0, 10'd3, 10'd900, 4'd1, 16'd1, 4'd1);
    send_word(CMD_SET_MODE, MODE_PROC);
    repeat (3) send_word(CMD_TICK, 2'($urandom));
    send_word(CMD_SET_MODE, MODE_ERROR);
    send_word(CMD_TICK, MODE_PROC);
    send_word(CMD_TICK, MODE_LISTEN);
    send_word(CMD_SET_MODE, MODE_LISTEN);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 15; snk_idle_pct = 70; end
        1: begin src_idle_pct = 70; snk_idle_pct = 15; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int k = 0; k < 2; k++) begin
        if (ph == 1 && k == 1) begin
          set_config(10'd1023, 10'd1023, 10'd0, 4'd15, 16'hFFFF, 4'd15);
        end else if (ph == 2 && k == 1) begin
          set_config(10'd0, 10'd0, 10'd0, 4'd1, 16'd1, 4'd1);
        end else begin
          lo = $urandom_range(900);
          hi = lo + $urandom_range(123);
          if ($urandom_range(5) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          set_config(10'($urandom_range(1023)), 10'(hi), 10'(lo),
                     4'($urandom_range(1, 15)), 16'($urandom_range(6)),
                     4'($urandom_range(4)));
        end
        // Hold the result side long enough for the block to back up
        if (ph == 2 && k == 0) hold_requests++;
        run_random(275);
        settle();
      end
    end

    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lmpg_pkg.sv
hw/rtl/lmpg_if.sv
hw/rtl/lmpg_cfg.sv
hw/rtl/lmpg_step.sv
hw/rtl/led_mode_pattern_generator.sv
test/lmpg_duty_checker.sv
test/led_mode_pattern_generator_test.sv
